// ----- sv/wft_pkg.sv -----
// ----------------------------------------------------------------------------
// wft_pkg: shared types and constants of the wrench frame transform
// Fixed-point widths, status codes, register indexes and the stage records
// that travel between the calibration lanes, rotation lanes and merge stage.
// ----------------------------------------------------------------------------
package wft_pkg;

  localparam int RAW_W    = 20;  // raw channel and bias, Q14.6
  localparam int DIF_W    = 21;  // raw - bias
  localparam int COEF_W   = 16;  // rotation, scale and offset entries
  localparam int SCL_W    = 17;  // scale with sign folded in
  localparam int CAL_W    = 38;  // calibrated channel, Q.19
  localparam int PROD_W   = 54;  // rotation entry * calibrated channel
  localparam int SUM_W    = 56;  // sum of three products, Q.33
  localparam int ROT_SH   = 27;  // Q.33 -> Q.6
  localparam int ROT_W    = 30;  // rotated force or moment, Q.6
  localparam int OFS_SH   = 13;  // Q.19 -> Q.6
  localparam int XP_W     = 46;  // offset * rotated force
  localparam int XD_W     = 47;  // difference of two cross products
  localparam int XR_W     = 34;  // rounded cross term
  localparam int TOT_W    = 35;  // moment plus cross term
  localparam int OUT_W    = 32;  // Q25.6 result
  localparam int STAMP_W  = 48;
  localparam int CFG_W    = 60;
  localparam int IDX_W    = 3;
  localparam int AXES     = 3;
  localparam int CHANNELS = 6;
  localparam int NEG_BIT  = 48;
  localparam int CFG_BIT  = 49;

  localparam logic [47:0] ROT_X_RST   = 48'd16384;
  localparam logic [47:0] ROT_Y_RST   = 48'd1073741824;
  localparam logic [47:0] ROT_Z_RST   = 48'd70368744177664;
  localparam logic [47:0] SCALE_RST   = 48'd35184908967936;
  localparam logic [59:0] BIAS_RST    = 60'd0;
  localparam logic [49:0] OFS_CTL_RST = 50'd0;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOCFG   = 2'd1,
    ST_INVALID = 2'd2,
    ST_OVF     = 2'd3
  } status_e;

  typedef enum logic [IDX_W-1:0] {
    REG_ROT_X   = 3'd0,
    REG_ROT_Y   = 3'd1,
    REG_ROT_Z   = 3'd2,
    REG_SCALE_F = 3'd3,
    REG_SCALE_M = 3'd4,
    REG_BIAS_F  = 3'd5,
    REG_BIAS_M  = 3'd6,
    REG_OFS_CTL = 3'd7
  } cfg_reg_e;

  typedef logic signed [CAL_W-1:0] cal_t;
  typedef logic signed [ROT_W-1:0] rot_t;

  typedef struct packed {
    logic               vld;
    status_e            status;
    logic [STAMP_W-1:0] stamp;
  } side_t;

  typedef struct packed {
    logic                            done;
    logic [CHANNELS-1:0][OUT_W-1:0]  wrench;
    logic                            valid;
    status_e                         status;
    logic [STAMP_W-1:0]              stamp;
  } result_t;

endpackage

// ----- sv/wft_cal_lane.sv -----
// ----------------------------------------------------------------------------
// wft_cal_lane: calibration of one channel
// Two stages: bias removal with sign folded into the scale, then the
// scale multiply giving the calibrated channel in Q.19.
// ----------------------------------------------------------------------------
module wft_cal_lane (
  input  logic                                clk_i,
  input  logic signed [wft_pkg::RAW_W-1:0]    raw_i,
  input  logic signed [wft_pkg::RAW_W-1:0]    bias_i,
  input  logic signed [wft_pkg::COEF_W-1:0]   scale_i,
  input  logic                                neg_i,
  output wft_pkg::cal_t                       cal_o
);
  import wft_pkg::*;

  logic signed [DIF_W-1:0] dif_q;
  logic signed [SCL_W-1:0] scl_q;
  cal_t                    cal_q;

  always_ff @(posedge clk_i) begin
    dif_q <= DIF_W'(raw_i) - DIF_W'(bias_i);
    scl_q <= neg_i ? -SCL_W'(scale_i) : SCL_W'(scale_i);
    cal_q <= dif_q * scl_q;
  end

  assign cal_o = cal_q;

endmodule

// ----- sv/wft_rot_lane.sv -----
// ----------------------------------------------------------------------------
// wft_rot_lane: one row of the rotation
// Multiplies the row's three entries with the calibrated force and moment,
// then sums and rounds half up to Q.6.
// ----------------------------------------------------------------------------
module wft_rot_lane (
  input  logic                 clk_i,
  input  wft_pkg::cal_t        cal_i [wft_pkg::CHANNELS],
  input  logic [47:0]          row_i,
  output wft_pkg::rot_t        force_o,
  output wft_pkg::rot_t        moment_o
);
  import wft_pkg::*;

  localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) <<< (ROT_SH - 1);

  logic signed [PROD_W-1:0] prod_q [CHANNELS];
  logic signed [SUM_W-1:0]  sum_f, sum_m, rnd_f, rnd_m;
  rot_t                     force_q, moment_q;

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_prod
    always_ff @(posedge clk_i) begin
      prod_q[ch] <= $signed(row_i[COEF_W*(ch%AXES) +: COEF_W]) * cal_i[ch];
    end
  end

  always_comb begin
    sum_f = SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]) + SUM_W'(prod_q[2]);
    sum_m = SUM_W'(prod_q[3]) + SUM_W'(prod_q[4]) + SUM_W'(prod_q[5]);
    rnd_f = (sum_f + RND) >>> ROT_SH;
    rnd_m = (sum_m + RND) >>> ROT_SH;
  end

  always_ff @(posedge clk_i) begin
    force_q  <= rnd_f[ROT_W-1:0];
    moment_q <= rnd_m[ROT_W-1:0];
  end

  assign force_o  = force_q;
  assign moment_o = moment_q;

endmodule

// ----- sv/wft_merge.sv -----
// ----------------------------------------------------------------------------
// wft_merge: lever-arm correction, saturation and status
// Forms offset x rotated force, adds it to the rotated moment, saturates all
// six results to 32 bits and resolves the status of the beat.
// ----------------------------------------------------------------------------
module wft_merge (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  wft_pkg::rot_t           force_i  [wft_pkg::AXES],
  input  wft_pkg::rot_t           moment_i [wft_pkg::AXES],
  input  logic [47:0]             ofs_i,
  input  wft_pkg::side_t          side_i,
  output wft_pkg::result_t        res_o
);
  import wft_pkg::*;

  localparam logic signed [XD_W-1:0] RND = XD_W'(1) <<< (OFS_SH - 1);

  logic signed [XP_W-1:0]  xp_pos_q [AXES];
  logic signed [XP_W-1:0]  xp_neg_q [AXES];
  rot_t                    force_q  [AXES];
  rot_t                    moment_q [AXES];
  side_t                   side_q;

  logic signed [XD_W-1:0]  xd    [AXES];
  logic signed [XD_W-1:0]  xsh   [AXES];
  logic signed [XR_W-1:0]  xr    [AXES];
  logic signed [TOT_W-1:0] tot   [CHANNELS];
  logic [CHANNELS-1:0]     ovf;
  logic [CHANNELS-1:0][OUT_W-1:0] sat;
  result_t                 res_d, res_q;

  for (genvar r = 0; r < AXES; r++) begin : g_cross
    always_ff @(posedge clk_i) begin
      xp_pos_q[r] <= $signed(ofs_i[COEF_W*((r+1)%AXES) +: COEF_W]) * force_i[(r+2)%AXES];
      xp_neg_q[r] <= $signed(ofs_i[COEF_W*((r+2)%AXES) +: COEF_W]) * force_i[(r+1)%AXES];
      force_q[r]  <= force_i[r];
      moment_q[r] <= moment_i[r];
    end

    always_comb begin
      xd[r]       = XD_W'(xp_pos_q[r]) - XD_W'(xp_neg_q[r]);
      xsh[r]      = (xd[r] + RND) >>> OFS_SH;
      xr[r]       = xsh[r][XR_W-1:0];
      tot[r]      = TOT_W'(force_q[r]);
      tot[r+AXES] = TOT_W'(moment_q[r]) + TOT_W'(xr[r]);
    end
  end

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_sat
    always_comb begin
      ovf[ch] = !((&tot[ch][TOT_W-1:OUT_W-1]) || !(|tot[ch][TOT_W-1:OUT_W-1]));
      if (ovf[ch]) begin
        sat[ch] = tot[ch][TOT_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
      end else begin
        sat[ch] = tot[ch][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else begin
      side_q <= side_i;
    end
  end

  always_comb begin
    res_d.done  = side_q.vld;
    res_d.stamp = side_q.stamp;
    if (side_q.status != ST_OK) begin
      res_d.wrench = '0;
      res_d.valid  = 1'b0;
      res_d.status = side_q.status;
    end else if (|ovf) begin
      res_d.wrench = sat;
      res_d.valid  = 1'b0;
      res_d.status = ST_OVF;
    end else begin
      res_d.wrench = sat;
      res_d.valid  = 1'b1;
      res_d.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ----- sv/wrench_frame_transform.sv -----
// ----------------------------------------------------------------------------
// wrench_frame_transform: six-axis force/torque sample to platform wrench
// Takes one sample on every clock where start is high; busy stays low, so a
// new sample may follow in the next cycle. Each result appears on done_o
// for one cycle, in sample order; the receiver cannot stall it. The six
// stages are bias removal, the calibration multiply in six channel lanes,
// the rotation products in three row lanes, the row sums, the lever-arm
// products, and the merge that saturates and sets the status. Registers
// are to be written on the cfg port only while the pipeline is empty; the
// block itself does not enforce this. They apply to samples taken afterwards.
// ----------------------------------------------------------------------------
module wrench_frame_transform (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [wft_pkg::IDX_W-1:0]         cfg_index_i,
  input  logic [wft_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic signed [wft_pkg::RAW_W-1:0]  force_x_i,
  input  logic signed [wft_pkg::RAW_W-1:0]  force_y_i,
  input  logic signed [wft_pkg::RAW_W-1:0]  force_z_i,
  input  logic signed [wft_pkg::RAW_W-1:0]  moment_x_i,
  input  logic signed [wft_pkg::RAW_W-1:0]  moment_y_i,
  input  logic signed [wft_pkg::RAW_W-1:0]  moment_z_i,
  input  logic                              sample_valid_i,
  input  logic                              stamp_valid_i,
  input  logic                              in_sensor_frame_i,
  input  logic [wft_pkg::STAMP_W-1:0]       stamp_i,
  output logic                              done_o,
  output logic signed [wft_pkg::OUT_W-1:0]  out_force_x_o,
  output logic signed [wft_pkg::OUT_W-1:0]  out_force_y_o,
  output logic signed [wft_pkg::OUT_W-1:0]  out_force_z_o,
  output logic signed [wft_pkg::OUT_W-1:0]  out_moment_x_o,
  output logic signed [wft_pkg::OUT_W-1:0]  out_moment_y_o,
  output logic signed [wft_pkg::OUT_W-1:0]  out_moment_z_o,
  output logic                              out_valid_o,
  output logic [1:0]                        status_o,
  output logic [wft_pkg::STAMP_W-1:0]       out_stamp_o
);
  import wft_pkg::*;

  localparam int SIDE_STAGES = 4;

  logic [47:0] rot_x_q, rot_y_q, rot_z_q;
  logic [47:0] scale_f_q, scale_m_q;
  logic [59:0] bias_f_q, bias_m_q;
  logic [49:0] ofs_ctl_q;

  logic [CHANNELS-1:0][RAW_W-1:0]  raw_w;
  logic [CHANNELS-1:0][RAW_W-1:0]  bias_w;
  logic [CHANNELS-1:0][COEF_W-1:0] scale_w;
  logic [AXES-1:0][47:0]           rows_w;
  cal_t                            cal_w [CHANNELS];
  rot_t                            force_w  [AXES];
  rot_t                            moment_w [AXES];
  side_t                           side_d;
  side_t                           side_q [SIDE_STAGES];
  result_t                         res_w;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_x_q   <= ROT_X_RST;
      rot_y_q   <= ROT_Y_RST;
      rot_z_q   <= ROT_Z_RST;
      scale_f_q <= SCALE_RST;
      scale_m_q <= SCALE_RST;
      bias_f_q  <= BIAS_RST;
      bias_m_q  <= BIAS_RST;
      ofs_ctl_q <= OFS_CTL_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ROT_X:   rot_x_q   <= cfg_data_i[47:0];
        REG_ROT_Y:   rot_y_q   <= cfg_data_i[47:0];
        REG_ROT_Z:   rot_z_q   <= cfg_data_i[47:0];
        REG_SCALE_F: scale_f_q <= cfg_data_i[47:0];
        REG_SCALE_M: scale_m_q <= cfg_data_i[47:0];
        REG_BIAS_F:  bias_f_q  <= cfg_data_i[59:0];
        REG_BIAS_M:  bias_m_q  <= cfg_data_i[59:0];
        REG_OFS_CTL: ofs_ctl_q <= cfg_data_i[49:0];
      endcase
    end
  end

  assign raw_w   = {moment_z_i, moment_y_i, moment_x_i, force_z_i, force_y_i, force_x_i};
  assign bias_w  = {bias_m_q, bias_f_q};
  assign scale_w = {scale_m_q, scale_f_q};
  assign rows_w  = {rot_z_q, rot_y_q, rot_x_q};

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_cal
    wft_cal_lane u_cal (
      .clk_i   (clk_i),
      .raw_i   (raw_w[ch]),
      .bias_i  (bias_w[ch]),
      .scale_i (scale_w[ch]),
      .neg_i   (ofs_ctl_q[NEG_BIT]),
      .cal_o   (cal_w[ch])
    );
  end

  for (genvar r = 0; r < AXES; r++) begin : g_rot
    wft_rot_lane u_rot (
      .clk_i    (clk_i),
      .cal_i    (cal_w),
      .row_i    (rows_w[r]),
      .force_o  (force_w[r]),
      .moment_o (moment_w[r])
    );
  end

  always_comb begin
    side_d.vld   = start && !busy;
    side_d.stamp = stamp_i;
    if (!ofs_ctl_q[CFG_BIT]) begin
      side_d.status = ST_NOCFG;
    end else if (!(sample_valid_i && stamp_valid_i && in_sensor_frame_i)) begin
      side_d.status = ST_INVALID;
    end else begin
      side_d.status = ST_OK;
    end
  end

  for (genvar s = 0; s < SIDE_STAGES; s++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[s] <= '0;
      end else if (s == 0) begin
        side_q[s] <= side_d;
      end else begin
        side_q[s] <= side_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  wft_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .force_i  (force_w),
    .moment_i (moment_w),
    .ofs_i    (ofs_ctl_q[47:0]),
    .side_i   (side_q[SIDE_STAGES-1]),
    .res_o    (res_w)
  );

  assign done_o         = res_w.done;
  assign out_force_x_o  = res_w.wrench[0];
  assign out_force_y_o  = res_w.wrench[1];
  assign out_force_z_o  = res_w.wrench[2];
  assign out_moment_x_o = res_w.wrench[3];
  assign out_moment_y_o = res_w.wrench[4];
  assign out_moment_z_o = res_w.wrench[5];
  assign out_valid_o    = res_w.valid;
  assign status_o       = res_w.status;
  assign out_stamp_o    = res_w.stamp;

  a_valid_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_valid_o == (status_o == ST_OK)))
    else $error("out_valid disagrees with status");

  a_zero_on_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_NOCFG || status_o == ST_INVALID) |->
      (out_force_x_o == '0 && out_force_y_o == '0 && out_force_z_o == '0 &&
       out_moment_x_o == '0 && out_moment_y_o == '0 && out_moment_z_o == '0))
    else $error("rejected beat carries a nonzero wrench");

  a_stamp_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_stamp_o == $past(stamp_i, 6)))
    else $error("stamp misaligned with its sample");

endmodule

// ----- dv/wrench_frame_transform_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wrench_frame_transform_tb: self-checking bench for the wrench transform
// A directed table walks the not-configured and invalid-input statuses, the
// extremes of every channel, both signs and extreme calibration settings.
// Randomized phases then reprogram every register and stream samples with
// random gaps. Each result beat is checked field by field against a pinned
// expectation or an in-bench fixed-point model of the calibration, rotation and lever arm.
// ----------------------------------------------------------------------------
module wrench_frame_transform_tb;
  import wft_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 6;
  localparam int PIPE_LATENCY   = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RAND_PHASES    = 10;
  localparam int PHASE_SAMPLES  = 193;
  localparam int REG_COUNT      = 8;
  localparam int COEF_REG_W     = AXES * COEF_W;
  localparam int CTL_REG_W      = CFG_BIT + 1;
  localparam int RAW_MAX        = 524287;
  localparam int RAW_MIN        = -524288;

  localparam logic [2:0] FLAGS_OK  = 3'b111;
  localparam logic [2:0] NO_SAMPLE = 3'b011;
  localparam logic [2:0] NO_STAMP  = 3'b101;
  localparam logic [2:0] NO_FRAME  = 3'b110;

  localparam logic [CFG_W-1:0] CTL_ON  = CFG_W'(1) << CFG_BIT;
  localparam logic [CFG_W-1:0] CTL_NEG = CFG_W'(1) << NEG_BIT;

  typedef struct packed {
    logic [CHANNELS-1:0][RAW_W-1:0] ch;
    logic [2:0]                     flags;
    logic [STAMP_W-1:0]             stamp;
  } sample_t;

  typedef struct packed {
    logic [CHANNELS-1:0][OUT_W-1:0] wr;
    logic                           vld;
    status_e                        st;
    logic [STAMP_W-1:0]             stamp;
  } wrench_t;

  typedef enum {STEP_CFG, STEP_ITEM} step_kind_e;

  typedef struct {
    step_kind_e       kind;
    cfg_reg_e         reg_id;
    logic [CFG_W-1:0] data;
    sample_t          smp;
    logic             pinned;
    wrench_t          want;
  } step_t;

  const string CH_NAME [CHANNELS] = '{"out_force_x", "out_force_y", "out_force_z",
                                      "out_moment_x", "out_moment_y", "out_moment_z"};

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  logic cfg_valid;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  sample_t drv;
  logic pin_en;
  wrench_t pin_want;

  logic done;
  logic signed [OUT_W-1:0] res_fx, res_fy, res_fz, res_mx, res_my, res_mz;
  logic res_valid;
  logic [1:0] res_status;
  logic [STAMP_W-1:0] res_stamp;

  logic [CFG_W-1:0] regfile [REG_COUNT];
  wrench_t wrench_due [$];
  wrench_t got;
  wrench_t want;
  int unsigned errors = 0;
  int unsigned quiet = 0;
  logic no_idle = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  wrench_frame_transform dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .force_x_i         (drv.ch[0]),
    .force_y_i         (drv.ch[1]),
    .force_z_i         (drv.ch[2]),
    .moment_x_i        (drv.ch[3]),
    .moment_y_i        (drv.ch[4]),
    .moment_z_i        (drv.ch[5]),
    .sample_valid_i    (drv.flags[2]),
    .stamp_valid_i     (drv.flags[1]),
    .in_sensor_frame_i (drv.flags[0]),
    .stamp_i           (drv.stamp),
    .done_o            (done),
    .out_force_x_o     (res_fx),
    .out_force_y_o     (res_fy),
    .out_force_z_o     (res_fz),
    .out_moment_x_o    (res_mx),
    .out_moment_y_o    (res_my),
    .out_moment_z_o    (res_mz),
    .out_valid_o       (res_valid),
    .status_o          (res_status),
    .out_stamp_o       (res_stamp)
  );

  function automatic logic [CFG_W-1:0] reset_of(cfg_reg_e r);
    case (r)
      REG_ROT_X:   return CFG_W'(ROT_X_RST);
      REG_ROT_Y:   return CFG_W'(ROT_Y_RST);
      REG_ROT_Z:   return CFG_W'(ROT_Z_RST);
      REG_SCALE_F,
      REG_SCALE_M: return CFG_W'(SCALE_RST);
      REG_BIAS_F,
      REG_BIAS_M:  return CFG_W'(BIAS_RST);
      default:     return CFG_W'(OFS_CTL_RST);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] width_mask(cfg_reg_e r);
    case (r)
      REG_BIAS_F,
      REG_BIAS_M:  return {CFG_W{1'b1}};
      REG_OFS_CTL: return {CFG_W{1'b1}} >> (CFG_W - CTL_REG_W);
      default:     return {CFG_W{1'b1}} >> (CFG_W - COEF_REG_W);
    endcase
  endfunction

  function automatic longint round_off(longint v, int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic logic [OUT_W-1:0] clip(longint v, inout logic ovf);
    if (v > longint'(32'sh7FFF_FFFF)) begin
      ovf = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -longint'(32'sh7FFF_FFFF) - 1) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return OUT_W'(v);
  endfunction

  function automatic wrench_t platform_wrench(sample_t s);
    wrench_t w;
    longint cal [CHANNELS];
    longint frc [AXES];
    longint mom [AXES];
    longint lever [AXES];
    longint acc_f, acc_m, cx, cy, cz;
    logic signed [COEF_W-1:0] e16;
    logic signed [RAW_W-1:0] raw20, bias20;
    logic ovf;
    w = '0;
    w.stamp = s.stamp;
    ovf = 1'b0;
    if (!regfile[REG_OFS_CTL][CFG_BIT]) begin
      w.st = ST_NOCFG;
    end else if (s.flags != FLAGS_OK) begin
      w.st = ST_INVALID;
    end else begin
      for (int i = 0; i < CHANNELS; i++) begin
        raw20  = s.ch[i];
        bias20 = regfile[i < AXES ? REG_BIAS_F : REG_BIAS_M][(i % AXES) * RAW_W +: RAW_W];
        e16    = regfile[i < AXES ? REG_SCALE_F : REG_SCALE_M][(i % AXES) * COEF_W +: COEF_W];
        cal[i] = (longint'(raw20) - longint'(bias20)) * longint'(e16);
        if (regfile[REG_OFS_CTL][NEG_BIT]) cal[i] = -cal[i];
      end
      for (int r = 0; r < AXES; r++) begin
        acc_f = 0;
        acc_m = 0;
        for (int k = 0; k < AXES; k++) begin
          e16 = regfile[r][k * COEF_W +: COEF_W];
          acc_f += longint'(e16) * cal[k];
          acc_m += longint'(e16) * cal[AXES + k];
        end
        frc[r] = round_off(acc_f, ROT_SH);
        mom[r] = round_off(acc_m, ROT_SH);
        e16 = regfile[REG_OFS_CTL][r * COEF_W +: COEF_W];
        lever[r] = longint'(e16);
      end
      cx = round_off(lever[1] * frc[2] - lever[2] * frc[1], OFS_SH);
      cy = round_off(lever[2] * frc[0] - lever[0] * frc[2], OFS_SH);
      cz = round_off(lever[0] * frc[1] - lever[1] * frc[0], OFS_SH);
      w.wr[0] = clip(frc[0], ovf);
      w.wr[1] = clip(frc[1], ovf);
      w.wr[2] = clip(frc[2], ovf);
      w.wr[3] = clip(mom[0] + cx, ovf);
      w.wr[4] = clip(mom[1] + cy, ovf);
      w.wr[5] = clip(mom[2] + cz, ovf);
      w.vld = !ovf;
      w.st  = ovf ? ST_OVF : ST_OK;
    end
    return w;
  endfunction

  function automatic sample_t sample_of(input int fx, fy, fz, mx, my, mz,
                                        input logic [2:0] flags,
                                        input logic [STAMP_W-1:0] stamp);
    sample_t s;
    s.ch[0] = RAW_W'(fx);
    s.ch[1] = RAW_W'(fy);
    s.ch[2] = RAW_W'(fz);
    s.ch[3] = RAW_W'(mx);
    s.ch[4] = RAW_W'(my);
    s.ch[5] = RAW_W'(mz);
    s.flags = flags;
    s.stamp = stamp;
    return s;
  endfunction

  function automatic sample_t flat(int v, logic [2:0] flags, logic [STAMP_W-1:0] stamp);
    return sample_of(v, v, v, v, v, v, flags, stamp);
  endfunction

  function automatic step_t cfg_row(cfg_reg_e r, logic [CFG_W-1:0] d);
    step_t t;
    t = '{kind: STEP_CFG, reg_id: r, data: d, smp: '0, pinned: 1'b0, want: '0};
    return t;
  endfunction

  function automatic step_t check_row(sample_t s);
    step_t t;
    t = '{kind: STEP_ITEM, reg_id: REG_ROT_X, data: '0, smp: s, pinned: 1'b0, want: '0};
    return t;
  endfunction

  function automatic step_t pin_row(sample_t s, int v, status_e st);
    step_t t;
    t = check_row(s);
    t.pinned = 1'b1;
    for (int i = 0; i < CHANNELS; i++) t.want.wr[i] = OUT_W'(v);
    t.want.vld   = (st == ST_OK);
    t.want.st    = st;
    t.want.stamp = s.stamp;
    return t;
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw();
    case ($urandom_range(0, 9))
      0:       return RAW_W'(RAW_MAX);
      1:       return RAW_W'(RAW_MIN);
      2:       return '0;
      3:       return '1;
      4, 5:    return RAW_W'(int'($urandom_range(0, 4000)) - 2000);
      default: return RAW_W'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 11))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h4000;
      3:       return 16'hC000;
      4:       return 16'h2000;
      5:       return 16'hFFFF;
      6:       return '0;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] pick_bias();
    case ($urandom_range(0, 9))
      0:       return RAW_W'(RAW_MAX);
      1:       return RAW_W'(RAW_MIN);
      2, 3, 4: return '0;
      5:       return RAW_W'(int'($urandom_range(0, 400)) - 200);
      default: return RAW_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_reg(cfg_reg_e r);
    logic [CFG_W-1:0] d;
    d = CFG_W'({$urandom, $urandom});
    if (r == REG_BIAS_F || r == REG_BIAS_M) begin
      for (int k = 0; k < AXES; k++) d[k * RAW_W +: RAW_W] = pick_bias();
    end else if (r != REG_OFS_CTL && $urandom_range(0, 7) == 0) begin
      d = reset_of(r);
    end else begin
      for (int k = 0; k < AXES; k++) d[k * COEF_W +: COEF_W] = pick_coef();
      if (r == REG_OFS_CTL) d[CFG_BIT] = ($urandom_range(0, 9) != 0);
    end
    return d;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    for (int i = 0; i < CHANNELS; i++) s.ch[i] = pick_raw();
    s.flags = ($urandom_range(0, 9) < 8) ? FLAGS_OK : 3'($urandom);
    s.stamp = STAMP_W'({$urandom, $urandom});
    return s;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic drive_sample(sample_t s, logic pinned, wrench_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start    <= 1'b1;
    drv      <= s;
    pin_en   <= pinned;
    pin_want <= w;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [CFG_W-1:0] d, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    if (last) cfg_valid <= 1'b0;
  endtask

  // hold off until the pipeline has emptied
  task automatic settle();
    start <= 1'b0;
    while (wrench_due.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready)
        regfile[cfg_index] = cfg_data & width_mask(cfg_reg_e'(cfg_index));
      if (start && !busy)
        wrench_due.push_back(pin_en ? pin_want : platform_wrench(drv));
      if (done) begin
        got.wr[0] = res_fx;
        got.wr[1] = res_fy;
        got.wr[2] = res_fz;
        got.wr[3] = res_mx;
        got.wr[4] = res_my;
        got.wr[5] = res_mz;
        got.vld   = res_valid;
        got.st    = status_e'(res_status);
        got.stamp = res_stamp;
        if (wrench_due.size() == 0) begin
          $error("result beat with no sample pending");
          errors++;
        end else begin
          want = wrench_due.pop_front();
          for (int i = 0; i < CHANNELS; i++) begin
            if (got.wr[i] !== want.wr[i]) begin
              $error("%s: expected %0d, got %0d", CH_NAME[i],
                     $signed(want.wr[i]), $signed(got.wr[i]));
              errors++;
            end
          end
          if (got.vld !== want.vld) begin
            $error("out_valid: expected %0b, got %0b", want.vld, got.vld);
            errors++;
          end
          if (got.st !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, got.st);
            errors++;
          end
          if (got.stamp !== want.stamp) begin
            $error("out_stamp: expected %h, got %h", want.stamp, got.stamp);
            errors++;
          end
        end
      end
      if ((cfg_valid && cfg_ready) || (start && !busy) || done) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    step_t plan [$];
    int off;
    rst_ni    = 1'b0;
    start     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    drv       = '0;
    pin_en    = 1'b0;
    pin_want  = '0;
    for (int r = 0; r < REG_COUNT; r++) regfile[r] = reset_of(cfg_reg_e'(r));
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    plan.push_back(pin_row(flat(0, FLAGS_OK, '0), 0, ST_NOCFG));
    plan.push_back(pin_row(flat(RAW_MAX, NO_SAMPLE, '1), 0, ST_NOCFG));
    plan.push_back(cfg_row(REG_OFS_CTL, CTL_ON));
    plan.push_back(pin_row(flat(RAW_MAX, FLAGS_OK, 48'hFFFF_FFFF_FFFF), RAW_MAX, ST_OK));
    plan.push_back(pin_row(flat(RAW_MIN, FLAGS_OK, 48'hAAAA_5555_AAAA), RAW_MIN, ST_OK));
    plan.push_back(pin_row(flat(7, NO_SAMPLE, 48'h1), 0, ST_INVALID));
    plan.push_back(pin_row(flat(7, NO_STAMP, 48'h2), 0, ST_INVALID));
    plan.push_back(pin_row(flat(7, NO_FRAME, 48'h4), 0, ST_INVALID));
    plan.push_back(pin_row(flat(7, 3'b000, 48'h8), 0, ST_INVALID));
    plan.push_back(check_row(sample_of(1234, -5678, 99999, -1, 0, RAW_MAX,
                                       FLAGS_OK, 48'h5555_AAAA_5555)));
    plan.push_back(cfg_row(REG_OFS_CTL, CTL_ON | CTL_NEG));
    plan.push_back(pin_row(flat(RAW_MAX, FLAGS_OK, 48'h10), -RAW_MAX, ST_OK));
    plan.push_back(pin_row(flat(RAW_MIN, FLAGS_OK, 48'h20), -RAW_MIN, ST_OK));
    plan.push_back(cfg_row(REG_ROT_X, 60'h8000_8000_8000));
    plan.push_back(cfg_row(REG_ROT_Y, 60'h7FFF_7FFF_7FFF));
    plan.push_back(cfg_row(REG_ROT_Z, 60'hFFFF_0001_8000));
    plan.push_back(cfg_row(REG_SCALE_F, 60'hFFF_8000_8000_8000));
    plan.push_back(cfg_row(REG_SCALE_M, 60'h7FFF_7FFF_7FFF));
    plan.push_back(cfg_row(REG_BIAS_F, 60'h7FFFF_7FFFF_7FFFF));
    plan.push_back(cfg_row(REG_BIAS_M, 60'h80000_80000_80000));
    plan.push_back(cfg_row(REG_OFS_CTL, 60'h3_8000_7FFF_8000));
    plan.push_back(check_row(flat(RAW_MIN, FLAGS_OK, 48'h40)));
    plan.push_back(check_row(flat(RAW_MAX, FLAGS_OK, 48'h80)));
    plan.push_back(check_row(sample_of(RAW_MIN, RAW_MIN, RAW_MIN, RAW_MAX, RAW_MAX, RAW_MAX,
                                       FLAGS_OK, 48'h100)));
    plan.push_back(check_row(sample_of(-1, 1, 0, RAW_MAX, RAW_MIN, 12345,
                                       FLAGS_OK, 48'h200)));
    plan.push_back(cfg_row(REG_OFS_CTL, 60'h2_7FFF_8000_7FFF));
    plan.push_back(check_row(flat(RAW_MAX, FLAGS_OK, 48'h400)));
    plan.push_back(check_row(sample_of(RAW_MAX, RAW_MIN, RAW_MAX, RAW_MIN, RAW_MAX, RAW_MIN,
                                       FLAGS_OK, 48'h800)));
    plan.push_back(cfg_row(REG_OFS_CTL, 60'hFFD_1234_5678_9ABC));
    plan.push_back(pin_row(flat(RAW_MAX, FLAGS_OK, 48'h0123_4567_89AB), 0, ST_NOCFG));
    plan.push_back(pin_row(flat(3, NO_FRAME, 48'h8000_0000_0000), 0, ST_NOCFG));

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) begin
        if (i == 0 || plan[i - 1].kind != STEP_CFG) settle();
        write_reg(plan[i].reg_id, plan[i].data,
                  i + 1 == plan.size() || plan[i + 1].kind != STEP_CFG);
      end else begin
        drive_sample(plan[i].smp, plan[i].pinned, plan[i].want);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      no_idle = ($urandom_range(0, 3) == 0);
      off = $urandom_range(0, REG_COUNT - 1);
      for (int k = 0; k < REG_COUNT; k++)
        write_reg(cfg_reg_e'((k + off) % REG_COUNT),
                  pick_reg(cfg_reg_e'((k + off) % REG_COUNT)), k == REG_COUNT - 1);
      repeat (PHASE_SAMPLES) drive_sample(random_sample(), 1'b0, '0);
    end

    settle();
    repeat (PIPE_LATENCY + 4) @(negedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
